// ===== design/svt_pkg.sv =====
// Shared types, constants and helpers for the sorted value table.
`default_nettype none

package svt_pkg;

   // Table size and the widths that follow from it.
   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Fixed field widths of the request and response words.
   localparam int VALUE_W       = 32;
   localparam int POSITION_W    = 6;
   localparam int ENTRY_COUNT_W = 7;

   // Operation codes.
   typedef enum logic [1:0] {
      CMD_INSERT   = 2'd0,
      CMD_REMOVE   = 2'd1,
      CMD_CONTAINS = 2'd2,
      CMD_GET      = 2'd3
   } cmd_type;

   // Response status codes.
   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } stat_type;

   // Request word.
   typedef struct packed {
      cmd_type                      cmd;
      logic signed [VALUE_W-1:0]    operand_value;
      logic [POSITION_W-1:0]        position;
   } req_type;

   // Response word.
   typedef struct packed {
      logic                         found;
      logic signed [VALUE_W-1:0]    read_value;
      logic [ENTRY_COUNT_W-1:0]     entry_count;
      stat_type                     status;
   } rsp_type;

   // Index register operations.
   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_ZERO,
      IDX_COUNT,
      IDX_INC,
      IDX_DEC
   } idx_op_type;

   // Read address choices.
   typedef enum logic [2:0] {
      RD_ZERO,
      RD_POS,
      RD_CNT_M1,
      RD_IDX_P1,
      RD_IDX_P2,
      RD_IDX_M2
   } rd_sel_type;

   // Write data choices.
   typedef enum logic {
      WD_OPERAND,
      WD_READ
   } wd_sel_type;

   // Count register operations.
   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   // Response read value choices.
   typedef enum logic [1:0] {
      RV_ZERO,
      RV_DATA,
      RV_ONES
   } rv_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_req;
      idx_op_type idx_op;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wd_sel_type wr_sel;
      cnt_op_type cnt_op;
      logic       rsp_en;
      logic       rsp_found;
      stat_type   rsp_status;
      rv_sel_type rsp_rv;
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      cmd_type cmd;
      logic    count_zero;
      logic    full;
      logic    pos_valid;
      logic    eq;
      logic    lt;
      logic    idx_last;
      logic    idx_near;
      logic    idx_one;
   } sts_type;

   // Low bits of the count as carried in the response word.
   function automatic logic [ENTRY_COUNT_W-1:0] count_field(input logic [CNT_W-1:0] cnt);
      logic [CNT_W+ENTRY_COUNT_W-1:0] wide;
      wide = {{ENTRY_COUNT_W{1'b0}}, cnt};
      return wide[ENTRY_COUNT_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/svt_datapath.sv =====
// Datapath of the sorted value table: entry memory, index, count and response word.
`default_nettype none

module svt_datapath
   import svt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   input  wire ctl_type ctl,
   output sts_type      sts,
   output rsp_type      rsp_data
);

   localparam int PW = CNT_W + 1;

   req_type                   req_ff;
   logic [IDX_W-1:0]          idx_ff;
   logic [IDX_W-1:0]          idx_in;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]          rd_addr;
   logic [VALUE_W-1:0]        wr_data;
   logic [VALUE_W-1:0]        rsp_value;
   rsp_type                   rsp_ff;

   // Entry store, one write and one registered read per cycle.
   logic [VALUE_W-1:0] mem [CAPACITY];

   // Latch the request word when an operation starts.
   always_ff @(posedge clock) begin
      if (ctl.load_req) begin
         req_ff <= req_data;
      end
   end

   // Next index value.
   always_comb begin
      case (ctl.idx_op)
         IDX_HOLD:  idx_in = idx_ff;
         IDX_ZERO:  idx_in = '0;
         IDX_COUNT: idx_in = IDX_W'(count_ff);
         IDX_INC:   idx_in = idx_ff + IDX_W'(1);
         IDX_DEC:   idx_in = idx_ff - IDX_W'(1);
         default:   idx_in = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   // Next entry count.
   always_comb begin
      case (ctl.cnt_op)
         CNT_HOLD: count_in = count_ff;
         CNT_INC:  count_in = count_ff + CNT_W'(1);
         CNT_DEC:  count_in = count_ff - CNT_W'(1);
         default:  count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Read address selection.
   always_comb begin
      case (ctl.rd_sel)
         RD_ZERO:   rd_addr = '0;
         RD_POS:    rd_addr = IDX_W'(req_ff.position);
         RD_CNT_M1: rd_addr = IDX_W'(count_ff - CNT_W'(1));
         RD_IDX_P1: rd_addr = idx_ff + IDX_W'(1);
         RD_IDX_P2: rd_addr = idx_ff + IDX_W'(2);
         RD_IDX_M2: rd_addr = idx_ff - IDX_W'(2);
         default:   rd_addr = '0;
      endcase
   end

   // Write data selection; the write address is always the index.
   assign wr_data = (ctl.wr_sel == WD_READ) ? rd_data_ff : req_ff.operand_value;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[idx_ff] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Status toward the controller.
   always_comb begin
      sts.cmd        = req_ff.cmd;
      sts.count_zero = (count_ff == '0);
      sts.full       = (count_ff == CNT_W'(CAPACITY));
      sts.pos_valid  = (32'(req_ff.position) < 32'(count_ff));
      sts.eq         = (rd_data_ff == req_ff.operand_value);
      sts.lt         = ($signed(req_ff.operand_value) < $signed(rd_data_ff));
      sts.idx_last   = ((PW'(idx_ff) + PW'(1)) >= PW'(count_ff));
      sts.idx_near   = ((PW'(idx_ff) + PW'(2)) >= PW'(count_ff));
      sts.idx_one    = (idx_ff == IDX_W'(1));
   end

   // Response word, carrying the count after this operation.
   always_comb begin
      case (ctl.rsp_rv)
         RV_ZERO: rsp_value = '0;
         RV_DATA: rsp_value = rd_data_ff;
         RV_ONES: rsp_value = '1;
         default: rsp_value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp_en) begin
         rsp_ff.found       <= ctl.rsp_found;
         rsp_ff.read_value  <= rsp_value;
         rsp_ff.entry_count <= count_field(count_in);
         rsp_ff.status      <= ctl.rsp_status;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// ===== design/svt_ctrl.sv =====
// Controller state machine of the sorted value table.
`default_nettype none

module svt_ctrl
   import svt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire sts_type sts,
   output ctl_type      ctl,
   output logic         busy,
   output logic         rsp_valid
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_INS_STEP,
      S_INS_PUT,
      S_SCAN,
      S_SHIFT,
      S_GET_WAIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;
   logic      busy_in;
   logic      valid_ff;
   logic      valid_in;

   // Next state and datapath commands.
   always_comb begin
      ctl      = '0;
      state_in = state_ff;
      busy_in  = busy_ff;
      valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load_req = 1'b1;
               busy_in      = 1'b1;
               state_in     = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            case (sts.cmd)
               CMD_INSERT: begin
                  if (sts.full) begin
                     ctl.rsp_en     = 1'b1;
                     ctl.rsp_status = ST_FULL;
                  end else if (sts.count_zero) begin
                     ctl.idx_op = IDX_COUNT;
                     state_in   = S_INS_PUT;
                  end else begin
                     ctl.idx_op = IDX_COUNT;
                     ctl.rd_en  = 1'b1;
                     ctl.rd_sel = RD_CNT_M1;
                     state_in   = S_INS_STEP;
                  end
               end
               CMD_REMOVE, CMD_CONTAINS: begin
                  if (sts.count_zero) begin
                     ctl.rsp_en     = 1'b1;
                     ctl.rsp_status = ST_MISS;
                  end else begin
                     ctl.idx_op = IDX_ZERO;
                     ctl.rd_en  = 1'b1;
                     ctl.rd_sel = RD_ZERO;
                     state_in   = S_SCAN;
                  end
               end
               CMD_GET: begin
                  if (sts.pos_valid) begin
                     ctl.rd_en  = 1'b1;
                     ctl.rd_sel = RD_POS;
                     state_in   = S_GET_WAIT;
                  end else begin
                     ctl.rsp_en     = 1'b1;
                     ctl.rsp_status = ST_MISS;
                     ctl.rsp_rv     = RV_ONES;
                  end
               end
               default: begin
                  ctl.rsp_en     = 1'b1;
                  ctl.rsp_status = ST_MISS;
               end
            endcase
         end

         // Walk down from the top, moving larger entries up by one.
         S_INS_STEP: begin
            if (sts.lt) begin
               ctl.wr_en  = 1'b1;
               ctl.wr_sel = WD_READ;
               ctl.idx_op = IDX_DEC;
               if (sts.idx_one) begin
                  state_in = S_INS_PUT;
               end else begin
                  ctl.rd_en  = 1'b1;
                  ctl.rd_sel = RD_IDX_M2;
               end
            end else begin
               ctl.wr_en      = 1'b1;
               ctl.wr_sel     = WD_OPERAND;
               ctl.cnt_op     = CNT_INC;
               ctl.rsp_en     = 1'b1;
               ctl.rsp_status = ST_DONE;
            end
         end

         S_INS_PUT: begin
            ctl.wr_en      = 1'b1;
            ctl.wr_sel     = WD_OPERAND;
            ctl.cnt_op     = CNT_INC;
            ctl.rsp_en     = 1'b1;
            ctl.rsp_status = ST_DONE;
         end

         // Forward search; the next entry is read while this one is compared.
         S_SCAN: begin
            ctl.rd_en  = 1'b1;
            ctl.rd_sel = RD_IDX_P1;
            if (sts.eq) begin
               if (sts.cmd == CMD_CONTAINS) begin
                  ctl.rsp_en     = 1'b1;
                  ctl.rsp_found  = 1'b1;
                  ctl.rsp_status = ST_DONE;
               end else if (sts.idx_last) begin
                  ctl.cnt_op     = CNT_DEC;
                  ctl.rsp_en     = 1'b1;
                  ctl.rsp_found  = 1'b1;
                  ctl.rsp_status = ST_DONE;
               end else begin
                  state_in = S_SHIFT;
               end
            end else if ((sts.cmd == CMD_CONTAINS && sts.lt) || sts.idx_last) begin
               ctl.rsp_en     = 1'b1;
               ctl.rsp_status = ST_MISS;
            end else begin
               ctl.idx_op = IDX_INC;
            end
         end

         // Close the gap: each entry above the removed one moves down by one.
         S_SHIFT: begin
            ctl.wr_en  = 1'b1;
            ctl.wr_sel = WD_READ;
            if (sts.idx_near) begin
               ctl.cnt_op     = CNT_DEC;
               ctl.rsp_en     = 1'b1;
               ctl.rsp_found  = 1'b1;
               ctl.rsp_status = ST_DONE;
            end else begin
               ctl.rd_en  = 1'b1;
               ctl.rd_sel = RD_IDX_P2;
               ctl.idx_op = IDX_INC;
            end
         end

         S_GET_WAIT: begin
            ctl.rsp_en     = 1'b1;
            ctl.rsp_found  = 1'b1;
            ctl.rsp_status = ST_DONE;
            ctl.rsp_rv     = RV_DATA;
         end

         default: begin
            state_in = S_IDLE;
            busy_in  = 1'b0;
         end
      endcase

      // Any response ends the operation.
      if (ctl.rsp_en) begin
         state_in = S_IDLE;
         busy_in  = 1'b0;
         valid_in = 1'b1;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

// ===== design/sorted_value_table.sv =====
// Top level of the sorted value table: a sorted multiset of signed 32-bit values.
// A dropped insert or a miss decided at once is answered from the dispatch state, a valid get
// at index after its registered read, and a walk once it reaches its end. The entry memory has
// one read and one write port, so a walk moves one entry a cycle. busy falls with the strobe,
// so the next word is accepted at the edge that takes the response; the receiver cannot stall.
// Synchronous reset empties the table and returns the controller to idle; entries are kept.
`default_nettype none

module sorted_value_table
   import svt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   ctl_type ctl;
   sts_type sts;

   // Sequencing of each operation.
   svt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .ctl       (ctl),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Entry memory and arithmetic.
   svt_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .ctl      (ctl),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

// ===== design/svt_checker.sv =====
// Port-level assertions for the sorted value table, bound to its top level.
`default_nettype none

module svt_checker
   import svt_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_data
);

   // An accepted word keeps the block busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after an accepted word");

   // The response strobe lasts one cycle.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   // A response ends the operation.
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy still high with the response");

   // A dropped insert reports a full table and no hit.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_FULL) |->
         (!rsp_data.found && rsp_data.entry_count == count_field(CNT_W'(CAPACITY))))
      else $error("full status with wrong count or found flag");

   // A hit always reports completion.
   a_found_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.found) |-> (rsp_data.status == ST_DONE))
      else $error("found flag with a failing status");

endmodule

bind sorted_value_table svt_checker u_svt_checker (.*);

`default_nettype wire
